// File: src/plist_pkg.sv
package plist_pkg;

	// fixed field widths
	localparam int DATA_W   = 32;
	localparam int ACT_W    = 3;
	localparam int POS_W    = 6;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 6;

	// default list depth
	localparam int CAPACITY_DEF = 32;

	typedef enum logic [ACT_W-1:0] {
		ACT_INS_FRONT = 3'd0,
		ACT_INS_BACK  = 3'd1,
		ACT_INS_AT    = 3'd2,
		ACT_DEL_FRONT = 3'd3,
		ACT_DEL_BACK  = 3'd4,
		ACT_DEL_AT    = 3'd5,
		ACT_READ_AT   = 3'd6
	} act_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// what the cell row does this cycle
	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INS  = 2'd1,
		OP_DEL  = 2'd2,
		OP_READ = 2'd3
	} cell_op_t;

	// command broadcast along the row; idx is sized to the largest depth
	typedef struct packed {
		cell_op_t                  op;
		logic [POS_W-1:0]          idx;
		logic signed [DATA_W-1:0]  value;
	} cell_cmd_t;

endpackage

// File: src/plist_req_if.sv
interface plist_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [plist_pkg::ACT_W-1:0]            action;
	logic signed [plist_pkg::DATA_W-1:0]    value;
	logic [plist_pkg::POS_W-1:0]            position;

	modport source (output valid, output action, output value, output position, input ready);
	modport sink   (input valid, input action, input value, input position, output ready);
endinterface

// File: src/plist_rsp_if.sv
interface plist_rsp_if;
	logic                                   valid;
	logic                                   ready;
	logic [plist_pkg::STAT_W-1:0]           status;
	logic [plist_pkg::COUNT_W-1:0]          count;
	logic signed [plist_pkg::DATA_W-1:0]    read_value;

	modport source (output valid, output status, output count, output read_value, input ready);
	modport sink   (input valid, input status, input count, input read_value, output ready);
endinterface

// File: src/plist_cell.sv
// One list slot. Opens a gap (takes its left neighbour) or closes one
// (takes its right neighbour) depending on where the command index lies.
module plist_cell #(
	parameter int Index = 0
) (
	input  logic                                clk,
	input  plist_pkg::cell_cmd_t                cmd,
	input  logic signed [plist_pkg::DATA_W-1:0] left,
	input  logic signed [plist_pkg::DATA_W-1:0] right,
	output logic signed [plist_pkg::DATA_W-1:0] data,
	output logic signed [plist_pkg::DATA_W-1:0] rd_data
);

	localparam logic [plist_pkg::POS_W-1:0] MyIdx = plist_pkg::POS_W'(Index);

	logic signed [plist_pkg::DATA_W-1:0] data_q;

	// slot update
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			plist_pkg::OP_INS: begin
				if (cmd.idx == MyIdx) begin
					data_q <= cmd.value;
				end else if (cmd.idx < MyIdx) begin
					data_q <= left;
				end
			end
			plist_pkg::OP_DEL: begin
				if (cmd.idx <= MyIdx) begin
					data_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;

	// gated read tap, OR-combined along the row
	assign rd_data = (cmd.op == plist_pkg::OP_READ && cmd.idx == MyIdx) ? data_q : '0;

endmodule

// File: src/plist_ctrl.sv
// Command decode: range checks against the current length, status,
// next length and the command for the cell row.
module plist_ctrl #(
	parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
	input  logic                                fire,
	input  logic [plist_pkg::ACT_W-1:0]         action,
	input  logic signed [plist_pkg::DATA_W-1:0] value,
	input  logic [plist_pkg::POS_W-1:0]         position,
	input  logic [$clog2(CAPACITY+1)-1:0]       length,
	output plist_pkg::cell_cmd_t                cmd,
	output plist_pkg::status_t                  status,
	output logic [$clog2(CAPACITY+1)-1:0]       length_next
);

	localparam int LW = $clog2(CAPACITY + 1);
	// compare width: holds length+1 and any position
	localparam int CW = ((LW > plist_pkg::POS_W) ? LW : plist_pkg::POS_W) + 1;
	localparam logic [LW-1:0] Full = LW'(CAPACITY);

	logic [CW-1:0]         len_x;
	logic [CW-1:0]         pos_x;
	logic [CW-1:0]         pos_m1;
	logic [CW-1:0]         len_m1;
	plist_pkg::cell_op_t   op;
	logic [CW-1:0]         idx;

	assign len_x  = CW'(length);
	assign pos_x  = CW'(position);
	assign pos_m1 = pos_x - CW'(1);
	assign len_m1 = len_x - CW'(1);

	// decode and range checks
	always_comb begin
		op     = plist_pkg::OP_HOLD;
		idx    = '0;
		status = plist_pkg::ST_OK;
		unique case (plist_pkg::act_t'(action))
			plist_pkg::ACT_INS_FRONT, plist_pkg::ACT_INS_BACK, plist_pkg::ACT_INS_AT: begin
				if (length == Full) begin
					status = plist_pkg::ST_FULL;
				end else if (plist_pkg::act_t'(action) == plist_pkg::ACT_INS_FRONT) begin
					op = plist_pkg::OP_INS;
				end else if (plist_pkg::act_t'(action) == plist_pkg::ACT_INS_BACK) begin
					op  = plist_pkg::OP_INS;
					idx = len_x;
				end else if (position == '0 || pos_x > len_x + CW'(1)) begin
					status = plist_pkg::ST_BADPOS;
				end else begin
					op  = plist_pkg::OP_INS;
					idx = pos_m1;
				end
			end
			plist_pkg::ACT_DEL_FRONT, plist_pkg::ACT_DEL_BACK, plist_pkg::ACT_DEL_AT: begin
				if (length == '0) begin
					status = plist_pkg::ST_EMPTY;
				end else if (plist_pkg::act_t'(action) == plist_pkg::ACT_DEL_FRONT) begin
					op = plist_pkg::OP_DEL;
				end else if (plist_pkg::act_t'(action) == plist_pkg::ACT_DEL_BACK) begin
					op  = plist_pkg::OP_DEL;
					idx = len_m1;
				end else if (position == '0 || pos_x > len_x) begin
					status = plist_pkg::ST_BADPOS;
				end else begin
					op  = plist_pkg::OP_DEL;
					idx = pos_m1;
				end
			end
			plist_pkg::ACT_READ_AT: begin
				if (position == '0 || pos_x > len_x) begin
					status = plist_pkg::ST_BADPOS;
				end else begin
					op  = plist_pkg::OP_READ;
					idx = pos_m1;
				end
			end
			default: begin
				status = plist_pkg::ST_BADPOS;
			end
		endcase
	end

	// command to the row only on an accepted request
	always_comb begin
		cmd.op    = fire ? op : plist_pkg::OP_HOLD;
		cmd.idx   = plist_pkg::POS_W'(idx);
		cmd.value = value;
		unique case (cmd.op)
			plist_pkg::OP_INS: length_next = length + LW'(1);
			plist_pkg::OP_DEL: length_next = length - LW'(1);
			default:           length_next = length;
		endcase
	end

endmodule

// File: src/positional_list_engine_core.sv
// Channel | Dir | Payload                          | Handshake
// req     | in  | action, value, position          | valid/ready
// rsp     | out | status, count, read_value        | valid/ready
//
// One request is taken per cycle; its response sits in the output register
// from the next cycle. The whole row of cells shifts in the accept cycle.
// A new request is taken while the response register is empty or being
// drained, so a stalled rsp channel stalls req after one request.
// Reset clears the length and the response valid; slot contents are left.
module positional_list_engine_core #(
	parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	plist_req_if.sink    req,
	plist_rsp_if.source  rsp
);

	localparam int LW = $clog2(CAPACITY + 1);

	logic                                fire;
	logic [LW-1:0]                       length_q;
	logic [LW-1:0]                       length_next;
	plist_pkg::cell_cmd_t                cmd;
	plist_pkg::status_t                  status;
	logic signed [plist_pkg::DATA_W-1:0] cell_data [CAPACITY];
	logic signed [plist_pkg::DATA_W-1:0] cell_rd   [CAPACITY];
	logic signed [plist_pkg::DATA_W-1:0] rd_value;

	logic                                rsp_valid_q;
	plist_pkg::status_t                  status_q;
	logic [plist_pkg::COUNT_W-1:0]       count_q;
	logic signed [plist_pkg::DATA_W-1:0] read_value_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	plist_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.fire        (fire),
		.action      (req.action),
		.value       (req.value),
		.position    (req.position),
		.length      (length_q),
		.cmd         (cmd),
		.status      (status),
		.length_next (length_next)
	);

	// row of slots, entry 0 is the front
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [plist_pkg::DATA_W-1:0] left_w;
		logic signed [plist_pkg::DATA_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		plist_cell #(.Index(i)) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.left    (left_w),
			.right   (right_w),
			.data    (cell_data[i]),
			.rd_data (cell_rd[i])
		);
	end

	// combine read taps; at most one is non-zero
	always_comb begin
		rd_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_value = rd_value | cell_rd[i];
		end
	end

	// length and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			length_q <= length_next;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q     <= status;
			count_q      <= plist_pkg::COUNT_W'(length_next);
			read_value_q <= rd_value;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.count      = count_q;
	assign rsp.read_value = read_value_q;

endmodule

// File: src/plist_checker.sv
module plist_checker #(
	parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [plist_pkg::STAT_W-1:0]        status,
	input logic [plist_pkg::COUNT_W-1:0]       count,
	input logic signed [plist_pkg::DATA_W-1:0] read_value
);

	// a waiting response is not dropped
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	// a stalled response keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(status) && $stable(count) && $stable(read_value))
		else $error("rsp payload changed while stalled");

	// every accepted request gives a response next cycle
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no response after accepted request");

	// a full refusal reports a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == plist_pkg::ST_FULL |-> count == plist_pkg::COUNT_W'(CAPACITY))
		else $error("full status with wrong count");

	// read data only on success; empty means zero entries
	a_status_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != plist_pkg::ST_OK |->
			read_value == '0 && (status != plist_pkg::ST_EMPTY || count == '0))
		else $error("read value or count inconsistent with status");

endmodule

bind positional_list_engine_core plist_checker #(.CAPACITY(CAPACITY)) u_plist_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.count      (rsp.count),
	.read_value (rsp.read_value)
);

// File: verif/tb_positional_list_engine_core.sv
module tb_positional_list_engine_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = plist_pkg::CAPACITY_DEF;
	localparam logic [plist_pkg::ACT_W-1:0] ACT_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 300;
	localparam int PHASE_ITEMS = 350;
	localparam int DIR_ROWS = 25;

	// one response as the list engine reports it
	typedef struct packed {
		plist_pkg::status_t                  status;
		logic [plist_pkg::COUNT_W-1:0]       count;
		logic signed [plist_pkg::DATA_W-1:0] read_value;
	} list_answer_t;

	// directed row; the answer is only meaningful where known is set
	typedef struct packed {
		logic [plist_pkg::ACT_W-1:0]         action;
		logic signed [plist_pkg::DATA_W-1:0] value;
		logic [plist_pkg::POS_W-1:0]         position;
		logic                                known;
		plist_pkg::status_t                  status;
		logic [plist_pkg::COUNT_W-1:0]       count;
		logic signed [plist_pkg::DATA_W-1:0] read_value;
	} dir_row_t;

	localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
		// empty list: deletes are no-ops; reads, bad codes and out-of-range inserts are rejected
		'{plist_pkg::ACT_DEL_FRONT, 32'sd0,        6'd0,  1'b1, plist_pkg::ST_EMPTY,  6'd0, 32'sd0},
		'{plist_pkg::ACT_DEL_BACK,  32'sh1234,     6'd0,  1'b1, plist_pkg::ST_EMPTY,  6'd0, 32'sd0},
		'{plist_pkg::ACT_DEL_AT,    32'sd0,        6'd63, 1'b1, plist_pkg::ST_EMPTY,  6'd0, 32'sd0},
		'{plist_pkg::ACT_READ_AT,   32'sd0,        6'd1,  1'b1, plist_pkg::ST_BADPOS, 6'd0, 32'sd0},
		'{ACT_UNUSED,               -32'sd1,       6'd63, 1'b1, plist_pkg::ST_BADPOS, 6'd0, 32'sd0},
		'{plist_pkg::ACT_INS_AT,    32'sd5,        6'd0,  1'b1, plist_pkg::ST_BADPOS, 6'd0, 32'sd0},
		'{plist_pkg::ACT_INS_AT,    32'sd5,        6'd2,  1'b1, plist_pkg::ST_BADPOS, 6'd0, 32'sd0},
		// build up with value extremes, then reads and bad positions
		'{plist_pkg::ACT_INS_FRONT, 32'sh7fffffff, 6'd0,  1'b1, plist_pkg::ST_OK,     6'd1, 32'sd0},
		'{plist_pkg::ACT_INS_BACK,  32'sh80000000, 6'd63, 1'b1, plist_pkg::ST_OK,     6'd2, 32'sd0},
		'{plist_pkg::ACT_INS_AT,    -32'sd1,       6'd3,  1'b1, plist_pkg::ST_OK,     6'd3, 32'sd0},
		'{plist_pkg::ACT_INS_AT,    32'sd0,        6'd1,  1'b1, plist_pkg::ST_OK,     6'd4, 32'sd0},
		'{plist_pkg::ACT_INS_AT,    32'sd42,       6'd63, 1'b1, plist_pkg::ST_BADPOS, 6'd4, 32'sd0},
		'{plist_pkg::ACT_INS_AT,    32'sh5a5a5a5a, 6'd3,  1'b0, plist_pkg::ST_OK,     6'd0, 32'sd0},
		'{plist_pkg::ACT_READ_AT,   32'sd0,        6'd1,  1'b0, plist_pkg::ST_OK,     6'd0, 32'sd0},
		'{plist_pkg::ACT_READ_AT,   32'sd0,        6'd3,  1'b0, plist_pkg::ST_OK,     6'd0, 32'sd0},
		'{plist_pkg::ACT_READ_AT,   32'sd0,        6'd5,  1'b0, plist_pkg::ST_OK,     6'd0, 32'sd0},
		'{plist_pkg::ACT_READ_AT,   32'sd0,        6'd6,  1'b1, plist_pkg::ST_BADPOS, 6'd5, 32'sd0},
		'{plist_pkg::ACT_READ_AT,   32'sd0,        6'd0,  1'b1, plist_pkg::ST_BADPOS, 6'd5, 32'sd0},
		'{plist_pkg::ACT_DEL_AT,    32'sd0,        6'd0,  1'b1, plist_pkg::ST_BADPOS, 6'd5, 32'sd0},
		'{plist_pkg::ACT_DEL_AT,    32'sd0,        6'd6,  1'b1, plist_pkg::ST_BADPOS, 6'd5, 32'sd0},
		// middle delete then both ends
		'{plist_pkg::ACT_DEL_AT,    32'sd0,        6'd2,  1'b0, plist_pkg::ST_OK,     6'd0, 32'sd0},
		'{plist_pkg::ACT_READ_AT,   32'sd0,        6'd2,  1'b0, plist_pkg::ST_OK,     6'd0, 32'sd0},
		'{plist_pkg::ACT_DEL_BACK,  32'sd0,        6'd0,  1'b0, plist_pkg::ST_OK,     6'd0, 32'sd0},
		'{plist_pkg::ACT_DEL_FRONT, 32'sd0,        6'd0,  1'b0, plist_pkg::ST_OK,     6'd0, 32'sd0},
		'{plist_pkg::ACT_READ_AT,   32'sd0,        6'd1,  1'b0, plist_pkg::ST_OK,     6'd0, 32'sd0}
	};

	logic clk;
	logic arst_n;

	plist_req_if req_if ();
	plist_rsp_if rsp_if ();

	positional_list_engine_core #(
		.CAPACITY(CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// shadow copy of the list
	logic signed [plist_pkg::DATA_W-1:0] shadow_list [0:CAP-1];
	int shadow_len = 0;

	list_answer_t awaited_answers [$];

	int error_cnt = 0;
	int sent_cnt = 0;
	int checked_cnt = 0;
	int cycle_cnt = 0;
	int full_refusals = 0;
	int empty_noops = 0;
	int bad_positions = 0;
	int good_reads = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	bit growing = 1'b1;

	// apply one command to the shadow list and return the answer it earns
	function automatic list_answer_t list_apply(logic [plist_pkg::ACT_W-1:0] act,
			logic signed [plist_pkg::DATA_W-1:0] val, logic [plist_pkg::POS_W-1:0] pos);
		list_answer_t ans;
		int at;
		int k;
		ans.status = plist_pkg::ST_OK;
		ans.read_value = '0;
		at = 0;
		case (act)
			plist_pkg::ACT_INS_FRONT, plist_pkg::ACT_INS_BACK, plist_pkg::ACT_INS_AT: begin
				if (shadow_len >= CAP) begin
					ans.status = plist_pkg::ST_FULL;
				end else if (act == plist_pkg::ACT_INS_AT &&
						(pos < 1 || int'(pos) > shadow_len + 1)) begin
					ans.status = plist_pkg::ST_BADPOS;
				end else begin
					if (act == plist_pkg::ACT_INS_BACK)
						at = shadow_len;
					else if (act == plist_pkg::ACT_INS_AT)
						at = int'(pos) - 1;
					for (k = shadow_len; k > at; k--)
						shadow_list[k] = shadow_list[k-1];
					shadow_list[at] = val;
					shadow_len++;
				end
			end
			plist_pkg::ACT_DEL_FRONT, plist_pkg::ACT_DEL_BACK, plist_pkg::ACT_DEL_AT: begin
				if (shadow_len == 0) begin
					ans.status = plist_pkg::ST_EMPTY;
				end else if (act == plist_pkg::ACT_DEL_AT &&
						(pos < 1 || int'(pos) > shadow_len)) begin
					ans.status = plist_pkg::ST_BADPOS;
				end else begin
					if (act == plist_pkg::ACT_DEL_BACK)
						at = shadow_len - 1;
					else if (act == plist_pkg::ACT_DEL_AT)
						at = int'(pos) - 1;
					for (k = at; k + 1 < shadow_len; k++)
						shadow_list[k] = shadow_list[k+1];
					shadow_len--;
				end
			end
			plist_pkg::ACT_READ_AT: begin
				if (pos < 1 || int'(pos) > shadow_len)
					ans.status = plist_pkg::ST_BADPOS;
				else
					ans.read_value = shadow_list[int'(pos) - 1];
			end
			default: ans.status = plist_pkg::ST_BADPOS;
		endcase
		ans.count = shadow_len[plist_pkg::COUNT_W-1:0];
		case (ans.status)
			plist_pkg::ST_FULL:   full_refusals++;
			plist_pkg::ST_EMPTY:  empty_noops++;
			plist_pkg::ST_BADPOS: bad_positions++;
			default:              if (act == plist_pkg::ACT_READ_AT) good_reads++;
		endcase
		return ans;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_cnt++;
	endtask

	// offer one request; record its answer once it is taken
	task automatic send_request(input logic [plist_pkg::ACT_W-1:0] act,
			input logic signed [plist_pkg::DATA_W-1:0] val,
			input logic [plist_pkg::POS_W-1:0] pos, input logic known,
			input list_answer_t given);
		list_answer_t ans;
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req_if.valid <= 1'b0;
		end
		@(negedge clk);
		req_if.valid    <= 1'b1;
		req_if.action   <= act;
		req_if.value    <= val;
		req_if.position <= pos;
		do @(posedge clk); while (!req_if.ready);
		ans = list_apply(act, val, pos);
		awaited_answers.push_back(known ? given : ans);
		sent_cnt++;
	endtask

	// sender pause: nothing offered until every answer is back
	task automatic drain_answers();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (awaited_answers.size() != 0)
			@(posedge clk);
	endtask

	// random request, steered to sweep the list between empty and full
	task automatic pick_request(output logic [plist_pkg::ACT_W-1:0] act,
			output logic signed [plist_pkg::DATA_W-1:0] val,
			output logic [plist_pkg::POS_W-1:0] pos);
		int roll;
		int upper;
		if (shadow_len == CAP && $urandom_range(3) == 0)
			growing = 1'b0;
		else if (shadow_len == 0 && $urandom_range(3) == 0)
			growing = 1'b1;
		case ($urandom_range(9))
			0: val = 32'sh80000000;
			1: val = 32'sh7fffffff;
			2: val = '0;
			3: val = -32'sd1;
			default: val = $urandom;
		endcase
		roll = $urandom_range(99);
		if (roll < 8) begin
			// noise, unused code included
			act = plist_pkg::ACT_W'($urandom_range(7));
			pos = plist_pkg::POS_W'($urandom_range(63));
		end else begin
			if (roll < (growing ? 68 : 28))
				act = plist_pkg::ACT_W'($urandom_range(2));
			else if (roll < 88)
				act = plist_pkg::ACT_W'(3 + $urandom_range(2));
			else
				act = plist_pkg::ACT_READ_AT;
			upper = (act == plist_pkg::ACT_INS_AT) ? shadow_len + 1 : shadow_len;
			if (upper == 0 || $urandom_range(9) == 0) begin
				case ($urandom_range(2))
					0: pos = '0;
					1: pos = plist_pkg::POS_W'(upper + 1);
					default: pos = plist_pkg::POS_W'($urandom_range(63));
				endcase
			end else begin
				pos = plist_pkg::POS_W'($urandom_range(upper, 1));
			end
		end
	endtask

	task automatic run_random(input int items, input int idle_pct, input int stall_pct);
		logic [plist_pkg::ACT_W-1:0] act;
		logic signed [plist_pkg::DATA_W-1:0] val;
		logic [plist_pkg::POS_W-1:0] pos;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (items) begin
			pick_request(act, val, pos);
			send_request(act, val, pos, 1'b0, '0);
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// response side: random stalls, plus a long hold-off when asked
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// compare each answer with the oldest one awaited
	always @(posedge clk) begin
		list_answer_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (awaited_answers.size() == 0) begin
				flag_mismatch($sformatf("response with none awaited: status %0d count %0d",
					rsp_if.status, rsp_if.count));
			end else begin
				want = awaited_answers.pop_front();
				if (rsp_if.status !== want.status)
					flag_mismatch($sformatf("status got %0d want %0d (answer %0d)",
						rsp_if.status, want.status, checked_cnt));
				if (rsp_if.count !== want.count)
					flag_mismatch($sformatf("count got %0d want %0d (answer %0d)",
						rsp_if.count, want.count, checked_cnt));
				if (rsp_if.read_value !== want.read_value)
					flag_mismatch($sformatf("read_value got %0d want %0d (answer %0d)",
						rsp_if.read_value, want.read_value, checked_cnt));
			end
			checked_cnt++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d answers still awaited",
				cycle_cnt, awaited_answers.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// stimulus
	initial begin
		list_answer_t given;
		req_if.valid    = 1'b0;
		req_if.action   = plist_pkg::ACT_INS_FRONT;
		req_if.value    = '0;
		req_if.position = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table, no idling
		for (int i = 0; i < DIR_ROWS; i++) begin
			given.status     = DIRECTED[i].status;
			given.count      = DIRECTED[i].count;
			given.read_value = DIRECTED[i].read_value;
			send_request(DIRECTED[i].action, DIRECTED[i].value, DIRECTED[i].position,
				DIRECTED[i].known, given);
		end
		drain_answers();

		// long receiver hold-off while requests keep coming
		hold_request = LONG_HOLD;
		run_random(PHASE_ITEMS, 0, 0);
		drain_answers();
		run_random(PHASE_ITEMS, 53, 0);
		drain_answers();
		run_random(PHASE_ITEMS, 0, 53);
		drain_answers();
		run_random(PHASE_ITEMS, 23, 23);
		drain_answers();
		repeat (8) @(posedge clk);

		$display("Covered %0d requests and %0d answers: %0d good reads, %0d bad positions,",
			sent_cnt, checked_cnt, good_reads, bad_positions);
		$display("%0d refusals on a full list and %0d deletes on an empty one; %0d mismatches.",
			full_refusals, empty_noops, error_cnt);
		if (error_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
src/plist_pkg.sv
src/plist_req_if.sv
src/plist_rsp_if.sv
src/plist_cell.sv
src/plist_ctrl.sv
src/positional_list_engine_core.sv
src/plist_checker.sv
verif/tb_positional_list_engine_core.sv
